/* src/p2f_pkg.sv */
// Package for the PCM to float converter: mode codes and register addresses.
// No dependencies.
`default_nettype none
package p2f_pkg;
  typedef enum logic [2:0] {
    MODE_ZERO  = 3'd0,
    MODE_FLOAT = 3'd1,
    MODE_S32   = 3'd2,
    MODE_S24   = 3'd3,
    MODE_S16   = 3'd4,
    MODE_U8    = 3'd5
  } mode_e;

  localparam logic [0:0] REG_WIDTH = 1'b0;
  localparam logic [0:0] REG_FLOAT = 1'b1;
endpackage
`default_nettype wire

/* src/pcm_to_float_converter.sv */
// PCM sample to IEEE binary32 converter, top level.
// Four register stages lie between an accepted word and the outputs.
// Throughput one word per cycle while the output is not stalled.
// Pipeline: magnitude, leading-one search, normalise/round, pack. A stall holds all stages.
// Reset: sample_width 32, float_flag 1, pipeline empty.
// Depends on p2f_pkg.
`default_nettype none
module pcm_to_float_converter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] sample_raw_i,
  input  wire logic        packet_end_in_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      float_bits_o,
  output logic             packet_end_out_o
);
  logic [5:0] width_q;
  logic       flag_q;
  logic       wr;
  logic       adv;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 6'd32;
      flag_q  <= 1'b1;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == p2f_pkg::REG_WIDTH) width_q <= pwdata[5:0];
      else flag_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == p2f_pkg::REG_WIDTH) prdata = {26'd0, width_q};
    else prdata = {31'd0, flag_q};
  end

  // pipeline advances unless the output word is held
  assign adv = !(valid_o && stall_i);
  assign stall_o = !adv;

  // stage 1: mode decode, sign and magnitude
  p2f_pkg::mode_e mode;
  logic [31:0] sv;
  logic        v1_q, pe1_q, neg1_q, pass1_q;
  logic [31:0] mag1_q, raw1_q;
  logic [4:0]  scl1_q;
  logic        zero1_q;

  always_comb begin
    mode = p2f_pkg::MODE_ZERO;
    sv = 32'd0;
    case (width_q)
      6'd32: mode = flag_q ? p2f_pkg::MODE_FLOAT : p2f_pkg::MODE_S32;
      6'd24: mode = p2f_pkg::MODE_S24;
      6'd16: mode = p2f_pkg::MODE_S16;
      6'd8:  mode = p2f_pkg::MODE_U8;
      default: mode = p2f_pkg::MODE_ZERO;
    endcase
    case (mode)
      p2f_pkg::MODE_S32: sv = sample_raw_i;
      p2f_pkg::MODE_S24: sv = {{8{sample_raw_i[23]}}, sample_raw_i[23:0]};
      p2f_pkg::MODE_S16: sv = {{16{sample_raw_i[15]}}, sample_raw_i[15:0]};
      p2f_pkg::MODE_U8:  sv = {{24{~sample_raw_i[7]}}, ~sample_raw_i[7], sample_raw_i[6:0]};
      default:           sv = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pe1_q   <= packet_end_in_i;
      raw1_q  <= sample_raw_i;
      pass1_q <= (mode == p2f_pkg::MODE_FLOAT);
      zero1_q <= (mode == p2f_pkg::MODE_ZERO);
      neg1_q  <= sv[31];
      mag1_q  <= sv[31] ? (32'd0 - sv) : sv;
      case (mode)
        p2f_pkg::MODE_S32: scl1_q <= 5'd31;
        p2f_pkg::MODE_S24: scl1_q <= 5'd23;
        p2f_pkg::MODE_S16: scl1_q <= 5'd15;
        default:           scl1_q <= 5'd7;
      endcase
    end
  end

  // stage 2: leading-one position
  logic [4:0]  top2;
  logic        v2_q, pe2_q, neg2_q, pass2_q, zero2_q;
  logic [31:0] mag2_q, raw2_q;
  logic [4:0]  scl2_q, top2_q;

  always_comb begin
    top2 = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag1_q[i]) top2 = 5'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pe2_q   <= pe1_q;
      raw2_q  <= raw1_q;
      pass2_q <= pass1_q;
      zero2_q <= zero1_q | (mag1_q == 32'd0);
      neg2_q  <= neg1_q;
      mag2_q  <= mag1_q;
      scl2_q  <= scl1_q;
      top2_q  <= top2;
    end
  end

  // stage 3: normalise to bit 31, round to 24 bits
  logic [31:0] nrm;
  logic        rnd;
  logic [24:0] q3;
  logic        v3_q, pe3_q, neg3_q, pass3_q, zero3_q;
  logic [31:0] raw3_q;
  logic [24:0] q3_q;
  logic [4:0]  scl3_q, top3_q;

  always_comb begin
    nrm = mag2_q << (5'd31 - top2_q);
    // guard bit and sticky, ties to even
    rnd = nrm[7] & ((|nrm[6:0]) | nrm[8]);
    q3  = {1'b0, nrm[31:8]} + {24'd0, rnd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pe3_q   <= pe2_q;
      raw3_q  <= raw2_q;
      pass3_q <= pass2_q;
      zero3_q <= zero2_q;
      neg3_q  <= neg2_q;
      q3_q    <= q3;
      scl3_q  <= scl2_q;
      top3_q  <= top2_q;
    end
  end

  // stage 4: exponent and pack, float pass-through or zero, into the output register
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [31:0] res;

  always_comb begin
    expo = 8'd127 + {3'd0, top3_q} - {3'd0, scl3_q} + {7'd0, q3_q[24]};
    frac = q3_q[24] ? q3_q[23:1] : q3_q[22:0];
    if (pass3_q)      res = raw3_q;
    else if (zero3_q) res = 32'd0;
    else              res = {neg3_q, expo, frac};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (adv) valid_o <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      float_bits_o     <= res;
      packet_end_out_o <= pe3_q;
    end
  end
endmodule
`default_nettype wire
